### rtl/mxt_pkg.sv
// ----------------------------------------------------------------------------
// mxt_pkg
// Shared widths and parameter defaults for the maximum-XOR-pair trie block.
// ----------------------------------------------------------------------------
package mxt_pkg;

  // Default set capacity and significant value width
  localparam int MaxValuesDef = 1024;
  localparam int ValueBitsDef = 31;

  // Fixed payload widths of the input and result channels
  localparam int InValueW = 31;
  localparam int OutXorW  = 31;

endpackage

### rtl/mxt_if.sv
// ----------------------------------------------------------------------------
// mxt_if
// Valid/ready channels: set members in, maximum XOR results out.
// ----------------------------------------------------------------------------
interface mxt_in_if;
  logic                         valid;
  logic                         ready;
  logic [mxt_pkg::InValueW-1:0] value;
  logic                         last;

  modport source (output valid, value, last, input ready);
  modport sink   (input valid, value, last, output ready);
endinterface

interface mxt_out_if;
  logic                        valid;
  logic                        ready;
  logic [mxt_pkg::OutXorW-1:0] max_xor;
  logic                        dropped;

  modport source (output valid, max_xor, dropped, input ready);
  modport sink   (input valid, max_xor, dropped, output ready);
endinterface

### rtl/mxt_ram.sv
// ----------------------------------------------------------------------------
// mxt_ram
// Single-port synchronous RAM, read-first, with a registered read.
// ----------------------------------------------------------------------------
module mxt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/max_xor_pair_trie.sv
// ----------------------------------------------------------------------------
// max_xor_pair_trie
// Largest XOR of any two members of a set, built over a binary trie in RAM.
// ----------------------------------------------------------------------------
//  channel | dir | payload                  | transfer
//  in_i    | in  | value[30:0], last        | valid & ready, one set member
//  out_o   | out | max_xor[30:0], dropped   | valid & ready, one per set
//
//  An inserted member moves one trie level per cycle through the single node
//  RAM port; a member beyond capacity is not stored. On last, the search
//  runs per answer bit: each stored value is read, then walked down the trie
//  one node per cycle until a path is missing or the prefix matches.
//  No clearing pass: the root lives in flops, inner nodes are zeroed when
//  allocated. in_i.ready is low while inserting or searching; a result that
//  waits on out_o holds the next search at its end, not the inserts.
// ----------------------------------------------------------------------------
module max_xor_pair_trie #(
  parameter int MAX_VALUES = mxt_pkg::MaxValuesDef,
  parameter int VALUE_BITS = mxt_pkg::ValueBitsDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  mxt_in_if.sink   in_i,
  mxt_out_if.source out_o
);

  localparam int NodeCount = MAX_VALUES * VALUE_BITS + 1;
  localparam int NW = $clog2(NodeCount);
  localparam int FW = $clog2(NodeCount + 1);
  localparam int AW = $clog2(MAX_VALUES);
  localparam int CW = $clog2(MAX_VALUES + 1);
  localparam int BW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int VB = VALUE_BITS;
  localparam int XW = (VALUE_BITS > mxt_pkg::InValueW) ? VALUE_BITS : mxt_pkg::InValueW;

  typedef struct packed {
    logic [NW-1:0] one;
    logic [NW-1:0] zero;
  } node_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_ALLOC,
    S_VREAD,
    S_VKEY,
    S_WALK,
    S_DONE
  } state_e;

  state_e          state_q, state_d;
  node_t           root_q, root_d;
  logic [FW-1:0]   nf_q, nf_d;
  logic [CW-1:0]   count_q, count_d;
  logic            ovf_q, ovf_d;
  logic            last_q, last_d;
  logic [VB-1:0]   val_q, val_d;
  logic [VB-1:0]   key_q, key_d;
  logic [NW-1:0]   cur_q, cur_d;
  logic            root_sel_q, root_sel_d;
  logic [BW-1:0]   bit_q, bit_d;
  logic [BW-1:0]   pos_q, pos_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [VB-1:0]   ans_q, ans_d;
  logic            out_valid_q, out_valid_d;
  logic [mxt_pkg::OutXorW-1:0] out_xor_q, out_xor_d;
  logic            out_drop_q, out_drop_d;

  // value store port
  logic            vs_we;
  logic [AW-1:0]   vs_addr;
  logic [VB-1:0]   vs_rdata;

  // trie node port
  logic            tr_we;
  logic [NW-1:0]   tr_addr;
  node_t           tr_wdata;
  node_t           tr_rdata;

  logic [XW-1:0]   in_ext;
  logic [XW-1:0]   ans_ext;
  logic [VB-1:0]   in_val;
  logic [VB-1:0]   pos_mask;
  node_t           node_cur;
  logic            dir_bit;
  logic [NW-1:0]   child;
  logic [NW-1:0]   nf_idx;
  logic            in_xfer;
  logic            full;

  assign in_ext   = XW'(in_i.value);
  assign in_val   = in_ext[VB-1:0];
  assign ans_ext  = XW'(ans_q);
  assign pos_mask = VB'(1) << pos_q;
  assign node_cur = root_sel_q ? root_q : tr_rdata;
  assign dir_bit  = (state_q == S_WALK) ? key_q[bit_q] : val_q[bit_q];
  assign child    = dir_bit ? node_cur.one : node_cur.zero;
  assign nf_idx   = nf_q[NW-1:0];
  assign in_xfer  = in_i.valid && in_i.ready;
  assign full     = (count_q == CW'(MAX_VALUES));

  assign in_i.ready    = (state_q == S_IDLE);
  assign out_o.valid   = out_valid_q;
  assign out_o.max_xor = out_xor_q;
  assign out_o.dropped = out_drop_q;

  mxt_ram #(.WIDTH(VB), .DEPTH(MAX_VALUES)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (vs_we),
    .addr_i  (vs_addr),
    .wdata_i (val_d),
    .rdata_o (vs_rdata)
  );

  mxt_ram #(.WIDTH(2 * NW), .DEPTH(NodeCount)) u_trie_ram (
    .clk_i   (clk_i),
    .we_i    (tr_we),
    .addr_i  (tr_addr),
    .wdata_i (tr_wdata),
    .rdata_o (tr_rdata)
  );

  always_comb begin
    state_d     = state_q;
    root_d      = root_q;
    nf_d        = nf_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    last_d      = last_q;
    val_d       = val_q;
    key_d       = key_q;
    cur_d       = cur_q;
    root_sel_d  = root_sel_q;
    bit_d       = bit_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    ans_d       = ans_q;
    out_valid_d = out_valid_q;
    out_xor_d   = out_xor_q;
    out_drop_d  = out_drop_q;
    vs_we       = 1'b0;
    vs_addr     = idx_q[AW-1:0];
    tr_we       = 1'b0;
    tr_addr     = child;
    tr_wdata    = tr_rdata;

    if (out_o.valid && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          last_d = in_i.last;
          if (full) begin
            ovf_d = 1'b1;
            if (in_i.last) begin
              idx_d   = '0;
              ans_d   = '0;
              pos_d   = BW'(VB - 1);
              state_d = S_VREAD;
            end
          end else begin
            val_d      = in_val;
            vs_we      = 1'b1;
            vs_addr    = count_q[AW-1:0];
            count_d    = count_q + CW'(1);
            bit_d      = BW'(VB - 1);
            root_sel_d = 1'b1;
            state_d    = S_INS;
          end
        end
      end

      S_INS: begin
        if (child == '0) begin
          nf_d = nf_q + FW'(1);
          if (root_sel_q) begin
            if (dir_bit) root_d.one = nf_idx;
            else         root_d.zero = nf_idx;
          end else begin
            tr_we   = 1'b1;
            tr_addr = cur_q;
            if (dir_bit) tr_wdata.one = nf_idx;
            else         tr_wdata.zero = nf_idx;
          end
          cur_d = nf_idx;
          if (bit_q != '0) begin
            bit_d   = bit_q - BW'(1);
            state_d = S_ALLOC;
          end
        end else begin
          cur_d      = child;
          root_sel_d = 1'b0;
          if (bit_q != '0) begin
            bit_d = bit_q - BW'(1);
          end
        end
        if (bit_q == '0) begin
          if (last_q) begin
            idx_d   = '0;
            ans_d   = '0;
            pos_d   = BW'(VB - 1);
            state_d = S_VREAD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      S_ALLOC: begin
        // fresh node: exactly one child, on the side of this bit
        tr_we    = 1'b1;
        tr_addr  = cur_q;
        tr_wdata = '0;
        if (val_q[bit_q]) tr_wdata.one = nf_idx;
        else              tr_wdata.zero = nf_idx;
        nf_d  = nf_q + FW'(1);
        cur_d = nf_idx;
        if (bit_q == '0) begin
          if (last_q) begin
            idx_d   = '0;
            ans_d   = '0;
            pos_d   = BW'(VB - 1);
            state_d = S_VREAD;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          bit_d = bit_q - BW'(1);
        end
      end

      S_VREAD: begin
        state_d = S_VKEY;
      end

      S_VKEY: begin
        key_d      = vs_rdata ^ (ans_q | pos_mask);
        bit_d      = BW'(VB - 1);
        root_sel_d = 1'b1;
        state_d    = S_WALK;
      end

      S_WALK: begin
        if ((child == '0) || (bit_q == pos_q)) begin
          if ((child == '0) && ((idx_q + CW'(1)) != count_q)) begin
            idx_d   = idx_q + CW'(1);
            state_d = S_VREAD;
          end else begin
            if (child != '0) begin
              ans_d = ans_q | pos_mask;
            end
            idx_d = '0;
            if (pos_q == '0) begin
              state_d = S_DONE;
            end else begin
              pos_d   = pos_q - BW'(1);
              state_d = S_VREAD;
            end
          end
        end else begin
          bit_d      = bit_q - BW'(1);
          root_sel_d = 1'b0;
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_xor_d   = ans_ext[mxt_pkg::OutXorW-1:0];
          out_drop_d  = ovf_q;
          root_d      = '0;
          nf_d        = FW'(1);
          count_d     = '0;
          ovf_d       = 1'b0;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      root_q      <= '0;
      nf_q        <= FW'(1);
      count_q     <= '0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      val_q       <= '0;
      key_q       <= '0;
      cur_q       <= '0;
      root_sel_q  <= 1'b1;
      bit_q       <= '0;
      pos_q       <= '0;
      idx_q       <= '0;
      ans_q       <= '0;
      out_valid_q <= 1'b0;
      out_xor_q   <= '0;
      out_drop_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      root_q      <= root_d;
      nf_q        <= nf_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      last_q      <= last_d;
      val_q       <= val_d;
      key_q       <= key_d;
      cur_q       <= cur_d;
      root_sel_q  <= root_sel_d;
      bit_q       <= bit_d;
      pos_q       <= pos_d;
      idx_q       <= idx_d;
      ans_q       <= ans_d;
      out_valid_q <= out_valid_d;
      out_xor_q   <= out_xor_d;
      out_drop_q  <= out_drop_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_VALUES))
    else $error("stored count above capacity");

  a_node_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nf_q <= FW'(NodeCount))
    else $error("trie node allocation past end of node RAM");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> full)
    else $error("overflow flagged with room left in the store");

  a_walk_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (bit_q >= pos_q))
    else $error("search walk went below the candidate prefix length");

endmodule

### sim/max_xor_pair_trie_tb.sv
// ----------------------------------------------------------------------------
// max_xor_pair_trie_tb
// Streams sets of values into the maximum-XOR-pair block and checks each
// result against a trie-based predictor kept inside this bench. Covers
// one-value sets, duplicates, extremes and shared prefixes, under random
// stalls on both channels.
// ----------------------------------------------------------------------------
module max_xor_pair_trie_tb;

  localparam int MaxVals   = mxt_pkg::MaxValuesDef;
  localparam int VBits     = mxt_pkg::ValueBitsDef;
  localparam int NodeCount = MaxVals * VBits + 1;
  localparam int TotalMembers = 450;
  localparam int DrainCycles  = 50;

  typedef struct packed {
    logic [mxt_pkg::InValueW-1:0] value;
    logic                         last;
  } set_member_t;

  typedef struct packed {
    logic [mxt_pkg::OutXorW-1:0] max_xor;
    logic                        dropped;
  } xor_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mxt_in_if  in_ch ();
  mxt_out_if out_ch ();

  max_xor_pair_trie i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #5 clk_i = ~clk_i;

  set_member_t pending_members[$];
  xor_result_t expected_results[$];
  set_member_t next_member;

  int unsigned total_sets;
  int unsigned set_xfers;
  int unsigned member_xfers;
  int unsigned results_checked;
  int unsigned dropped_sets;
  int unsigned error_count;

  // Predictor state: one set under construction
  logic [VBits-1:0] set_vals [MaxVals];
  int unsigned      child_one [NodeCount];
  int unsigned      child_zero [NodeCount];
  int unsigned      set_count;
  int unsigned      node_used;
  bit               set_dropped;

  function automatic void clear_set_state();
    child_one[0]  = 0;
    child_zero[0] = 0;
    set_count     = 0;
    node_used     = 1;
    set_dropped   = 1'b0;
  endfunction

  function automatic void trie_add(logic [VBits-1:0] v);
    int unsigned node;
    int unsigned nxt;
    node = 0;
    for (int b = VBits - 1; b >= 0; b--) begin
      nxt = v[b] ? child_one[node] : child_zero[node];
      if (nxt == 0) begin
        nxt = node_used;
        node_used++;
        child_one[nxt]  = 0;
        child_zero[nxt] = 0;
        if (v[b]) child_one[node] = nxt;
        else child_zero[node] = nxt;
      end
      node = nxt;
    end
  endfunction

  // top len bits of key form a path from the root
  function automatic bit trie_has_path(logic [VBits-1:0] key, int len);
    int unsigned node;
    node = 0;
    for (int b = VBits - 1; b >= VBits - len; b--) begin
      node = key[b] ? child_one[node] : child_zero[node];
      if (node == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // greedy top-down: keep a bit when some member XOR candidate is a prefix
  function automatic logic [VBits-1:0] best_xor();
    logic [VBits-1:0] ans;
    logic [VBits-1:0] probe;
    ans = '0;
    for (int len = 1; len <= VBits; len++) begin
      probe = VBits'(((ans << 1) | VBits'(1)) << (VBits - len));
      ans   = ans << 1;
      for (int i = 0; i < set_count; i++) begin
        if (trie_has_path(set_vals[i] ^ probe, len)) begin
          ans[0] = 1'b1;
          break;
        end
      end
    end
    return ans;
  endfunction

  function automatic void take_member(set_member_t m);
    xor_result_t r;
    if (set_count < MaxVals) begin
      set_vals[set_count] = m.value;
      set_count++;
      trie_add(m.value);
    end else begin
      set_dropped = 1'b1;
    end
    if (m.last) begin
      r.max_xor = best_xor();
      r.dropped = set_dropped;
      expected_results.push_back(r);
      clear_set_state();
    end
  endfunction

  // three stall mixes, stepped by the number of sets transferred so far
  function automatic int unsigned stall_percent(bit receiver);
    int unsigned phase;
    phase = (total_sets == 0) ? 2 : set_xfers * 3 / total_sets;
    case (phase)
      0: return receiver ? 74 : 26;
      1: return receiver ? 26 : 74;
      default: return 0;
    endcase
  endfunction

  function automatic void push_member(logic [VBits-1:0] v, bit last);
    set_member_t m;
    m.value = v;
    m.last  = last;
    pending_members.push_back(m);
    if (last) total_sets++;
  endfunction

  function automatic void push_random_set();
    int unsigned      n;
    int unsigned      style;
    logic [VBits-1:0] base;
    logic [VBits-1:0] mask;
    logic [VBits-1:0] v;
    n     = ($urandom_range(9) == 0) ? $urandom_range(12, 7) : $urandom_range(5, 1);
    style = $urandom_range(3);
    base  = VBits'($urandom);
    mask  = (31'h1 << $urandom_range(30, 1)) - 31'h1;
    for (int i = 0; i < n; i++) begin
      case (style)
        0: v = VBits'($urandom);
        1: v = base ^ (VBits'($urandom) & mask);   // shared high prefix
        2: v = $urandom_range(1) ? base : ~base;
        default: begin
          case ($urandom_range(2))
            0: v = '0;
            1: v = '1;
            default: v = VBits'($urandom);
          endcase
        end
      endcase
      push_member(v, i == n - 1);
    end
  endfunction

  function automatic void report_mismatch(string what);
    error_count++;
    if (error_count <= 10) $display("[%0t] MISMATCH: %s", $realtime, what);
  endfunction

  // Driver: presents the next pending member, predicts on each transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.value <= '0;
      in_ch.last  <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        take_member({in_ch.value, in_ch.last});
        member_xfers++;
        if (in_ch.last) set_xfers++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_members.size() > 0 && $urandom_range(99) >= stall_percent(1'b0)) begin
          next_member = pending_members.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.value <= next_member.value;
          in_ch.last  <= next_member.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result max_xor %h dropped %0d",
                                    out_ch.max_xor, out_ch.dropped));
        end else begin
          xor_result_t exp_r;
          exp_r = expected_results.pop_front();
          results_checked++;
          if (exp_r.dropped) dropped_sets++;
          if (out_ch.max_xor !== exp_r.max_xor)
            report_mismatch($sformatf("max_xor expected %h got %h",
                                      exp_r.max_xor, out_ch.max_xor));
          if (out_ch.dropped !== exp_r.dropped)
            report_mismatch($sformatf("dropped expected %0d got %0d",
                                      exp_r.dropped, out_ch.dropped));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= stall_percent(1'b1));
    end
  end

  initial begin
    rst_ni = 1'b0;
    clear_set_state();

    // directed sets
    push_member(31'h0000_0000, 1'b1);                  // single value, zero
    push_member(31'h7FFF_FFFF, 1'b1);                  // single value, all ones
    push_member(31'h0000_0000, 1'b0);
    push_member(31'h7FFF_FFFF, 1'b1);                  // full-width XOR
    push_member(31'h0000_0005, 1'b0);
    push_member(31'h0000_0005, 1'b1);                  // duplicates give zero
    push_member(31'h4000_0000, 1'b0);
    push_member(31'h3FFF_FFFF, 1'b1);
    push_member(31'h0000_0001, 1'b0);
    push_member(31'h0000_0002, 1'b0);
    push_member(31'h0000_0003, 1'b1);
    push_member(31'h2AAA_AAAA, 1'b0);
    push_member(31'h5555_5555, 1'b0);
    push_member(31'h1555_5555, 1'b1);
    push_member(31'h1234_5678, 1'b0);
    push_member(31'h1234_5679, 1'b1);                  // differ in bit 0 only

    while (pending_members.size() < TotalMembers) push_random_set();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_members.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Checked %0d set results (%0d with dropped members) from %0d member transfers,",
             results_checked, dropped_sets, member_xfers);
    $display("over sender/receiver stall mixes 26/74, 74/26 and none; %0d mismatches.",
             error_count);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("Timeout with %0d results still expected", expected_results.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

### max_xor_pair_trie.f
rtl/mxt_pkg.sv
rtl/mxt_if.sv
rtl/mxt_ram.sv
rtl/max_xor_pair_trie.sv
sim/max_xor_pair_trie_tb.sv
